@@ src/directional_passage_classifier_defines.svh @@
// Assertion macros for the directional passage classifier.
`ifndef DIRECTIONAL_PASSAGE_CLASSIFIER_DEFINES_SVH
`define DIRECTIONAL_PASSAGE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define DPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpc assertion failed");
`define DPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpc assertion failed");
`else
`define DPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/dpc_pkg.sv @@
// Shared types and constants of the directional passage classifier.
package dpc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_W     = 16;
    localparam int STAMP_W     = 32;
    localparam int SETTLE_W    = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd700;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_SETTLE_TIME = 1'b0;

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CHILD_IN  = 3'd1,
        EV_ADULT_IN  = 3'd2,
        EV_CHILD_OUT = 3'd3,
        EV_ADULT_OUT = 3'd4
    } event_code_t;

    typedef struct packed {
        logic               outside_edge;
        logic               outside_level;
        logic               inside_edge;
        logic               inside_level;
        logic               top_edge;
        logic [STAMP_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] child_total;
        logic signed [TOTAL_W-1:0] adult_total;
        event_code_t               event_code;
    } result_t;

    // low TOTAL_W bits of the count, sign-extended first when the count is narrower
    function automatic logic signed [TOTAL_W-1:0] to_total(
        input logic signed [COUNT_WIDTH-1:0] v
    );
        logic signed [63:0] wide;
        begin
            wide = 64'(v);
            return wide[TOTAL_W-1:0];
        end
    endfunction

endpackage

@@ src/dpc_cfg_regs.sv @@
// APB configuration register bank: settle time.
module dpc_cfg_regs
    import dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SETTLE_W-1:0]   settle_time_ms
);

    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;
    logic                wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2:2] == REG_SETTLE_TIME);

    always_comb
    begin
        settle_next = settle_reg;
        if (wr_hit)
        begin
            settle_next = pwdata[SETTLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RESET;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == REG_SETTLE_TIME)
        begin
            prdata = CFG_DATA_W'(settle_reg);
        end
    end

    assign settle_time_ms = settle_reg;

endmodule

@@ src/dpc_tracker.sv @@
// Passage tracking state and saturating totals, updated once per item.
module dpc_tracker
    import dpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sample_t             sample,
    input  logic [SETTLE_W-1:0] settle_time_ms,
    output result_t             result
);

    logic                          active_reg, active_next;
    logic                          going_in_reg, going_in_next;
    logic                          going_out_reg, going_out_next;
    logic                          far_in_reg, far_in_next;
    logic                          far_out_reg, far_out_next;
    logic                          tall_reg, tall_next;
    logic [STAMP_W-1:0]            stamp_reg, stamp_next;
    logic signed [COUNT_WIDTH-1:0] child_reg, child_next;
    logic signed [COUNT_WIDTH-1:0] adult_reg, adult_next;
    logic [STAMP_W-1:0]            elapsed;
    logic                          settled;
    event_code_t                   ev;

    always_comb
    begin
        active_next    = active_reg;
        going_in_next  = going_in_reg;
        going_out_next = going_out_reg;
        far_in_next    = far_in_reg;
        far_out_next   = far_out_reg;
        tall_next      = tall_reg;
        stamp_next     = stamp_reg;
        child_next     = child_reg;
        adult_next     = adult_reg;
        ev             = EV_NONE;

        // entry start has priority over an exit start in the same tick
        if (sample.outside_edge && !sample.inside_level && !active_next)
        begin
            active_next    = 1'b1;
            going_in_next  = 1'b1;
            going_out_next = 1'b0;
            stamp_next     = sample.now_ms;
        end
        if (sample.inside_edge && !sample.outside_level && !active_next)
        begin
            active_next    = 1'b1;
            going_out_next = 1'b1;
            going_in_next  = 1'b0;
            stamp_next     = sample.now_ms;
        end
        if (active_next && sample.top_edge)
        begin
            active_next = 1'b0;
            tall_next   = 1'b1;
        end
        if (going_in_next)
        begin
            if (sample.inside_edge)
            begin
                far_in_next = 1'b1;
            end
        end
        else if (going_out_next)
        begin
            if (sample.outside_edge)
            begin
                far_out_next = 1'b1;
            end
        end

        elapsed = sample.now_ms - stamp_next;
        settled = elapsed > STAMP_W'(settle_time_ms);

        priority if (going_in_next && far_in_next && settled)
        begin
            if (!tall_next)
            begin
                child_next = (child_reg == COUNT_MAX) ? COUNT_MAX
                                                      : child_reg + COUNT_WIDTH'(1);
                ev         = EV_CHILD_IN;
            end
            else
            begin
                adult_next = (adult_reg == COUNT_MAX) ? COUNT_MAX
                                                      : adult_reg + COUNT_WIDTH'(1);
                tall_next  = 1'b0;
                ev         = EV_ADULT_IN;
            end
            active_next    = 1'b0;
            going_in_next  = 1'b0;
            going_out_next = 1'b0;
            far_in_next    = 1'b0;
            far_out_next   = 1'b0;
        end
        else if (going_out_next && far_out_next && settled)
        begin
            if (!tall_next)
            begin
                child_next = (child_reg == COUNT_MIN) ? COUNT_MIN
                                                      : child_reg - COUNT_WIDTH'(1);
                ev         = EV_CHILD_OUT;
            end
            else
            begin
                adult_next = (adult_reg == COUNT_MIN) ? COUNT_MIN
                                                      : adult_reg - COUNT_WIDTH'(1);
                tall_next  = 1'b0;
                ev         = EV_ADULT_OUT;
            end
            active_next    = 1'b0;
            going_in_next  = 1'b0;
            going_out_next = 1'b0;
            far_in_next    = 1'b0;
            far_out_next   = 1'b0;
        end
        else
        begin
            ev = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            going_in_reg  <= 1'b0;
            going_out_reg <= 1'b0;
            far_in_reg    <= 1'b0;
            far_out_reg   <= 1'b0;
            tall_reg      <= 1'b0;
            stamp_reg     <= '0;
            child_reg     <= '0;
            adult_reg     <= '0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            going_in_reg  <= going_in_next;
            going_out_reg <= going_out_next;
            far_in_reg    <= far_in_next;
            far_out_reg   <= far_out_next;
            tall_reg      <= tall_next;
            stamp_reg     <= stamp_next;
            child_reg     <= child_next;
            adult_reg     <= adult_next;
        end
    end

    assign result.child_total = to_total(child_next);
    assign result.adult_total = to_total(adult_next);
    assign result.event_code  = ev;

endmodule

@@ src/directional_passage_classifier.sv @@
// Top level of the directional passage classifier: item registers, tracker, config.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one sensor sample tick per item:
//   beam edge/level bits and a millisecond timestamp. Output channel
//   (out_valid/out_ready) returns exactly one result per sample: the child and
//   adult totals after that tick and an event code for a counted passage.
//   out_valid rises after an accepted item has passed the input register and
//   the tracker logic into the result register; a receiver stall holds it in
//   the input register. Throughput is one item per clock while the receiver
//   does not stall; the tracker registers its next passage state on each step.
//   When the receiver stalls, one more item is held in the input register and
//   in_ready then drops until the result is taken.
//   pready is always high. Reset (rst_n low, asynchronous) clears the passage flags
//   and both totals and loads settle_time_ms with 700. The user writes the settle
//   time over the APB port at address 0 while the block is idle; no check is made.
`include "directional_passage_classifier_defines.svh"

module directional_passage_classifier
    import dpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      outside_edge,
    input  logic                      outside_level,
    input  logic                      inside_edge,
    input  logic                      inside_level,
    input  logic                      top_edge,
    input  logic [STAMP_W-1:0]        now_ms,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [TOTAL_W-1:0] child_total,
    output logic signed [TOTAL_W-1:0] adult_total,
    output logic [2:0]                event_code
);

    logic                in_valid_reg, in_valid_next;
    sample_t             in_sample_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_result_reg;
    result_t             result;
    logic                step;
    logic                in_fire;
    logic [SETTLE_W-1:0] settle_time_ms;

    dpc_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .settle_time_ms (settle_time_ms)
    );

    // the held item moves on when the result register is free or being emptied
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    dpc_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .sample         (in_sample_reg),
        .settle_time_ms (settle_time_ms),
        .result         (result)
    );

    always_comb
    begin
        in_valid_next  = in_fire || (in_valid_reg && !step);
        out_valid_next = step || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_sample_reg.outside_edge  <= outside_edge;
            in_sample_reg.outside_level <= outside_level;
            in_sample_reg.inside_edge   <= inside_edge;
            in_sample_reg.inside_level  <= inside_level;
            in_sample_reg.top_edge      <= top_edge;
            in_sample_reg.now_ms        <= now_ms;
        end
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign child_total = out_result_reg.child_total;
    assign adult_total = out_result_reg.adult_total;
    assign event_code  = out_result_reg.event_code;

    `DPC_ASSERT_SAME(a_stall_means_full, clk, rst_n, !in_ready, in_valid_reg && out_valid_reg)
    `DPC_ASSERT_NEXT(a_step_fills_output, clk, rst_n, step, out_valid_reg)
    `DPC_ASSERT_NEXT(a_held_item_stable, clk, rst_n, in_valid_reg && !step,
                     in_valid_reg && $stable(in_sample_reg))

endmodule
